FILE: design/motion_peak_gesture_classifier_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motion peak gesture classifier
// Implication and next-cycle checks; empty when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef MOTION_PEAK_GESTURE_CLASSIFIER_MACROS_SVH
`define MOTION_PEAK_GESTURE_CLASSIFIER_MACROS_SVH

`ifndef ASSERT_OFF
`define MPGC_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpgc: same-cycle check failed");
`define MPGC_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpgc: next-cycle check failed");
`else
`define MPGC_ASSERT_IMP(name, clk, rst, ante, cons)
`define MPGC_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

FILE: design/mpgc_pkg.sv
// ----------------------------------------------------------------------------
// mpgc_pkg
// Shared widths, codes and types of the motion peak gesture classifier.
// ----------------------------------------------------------------------------
package mpgc_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int TIME_WIDTH   = 16;

  // common width for comparing samples against the 15/16 bit thresholds
  localparam int CMP_W = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 1;

  localparam int TRK_N  = 4;
  localparam int TRK_VC = 0;
  localparam int TRK_VT = 1;
  localparam int TRK_LC = 2;
  localparam int TRK_LT = 3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_COUNT   = 2'd2;

  localparam logic [0:0] KIND_SAMPLE = 1'b0;
  localparam logic [0:0] KIND_END    = 1'b1;

  typedef enum logic [2:0] {
    GST_NONE  = 3'd0,
    GST_CW    = 3'd1,
    GST_CCW   = 3'd2,
    GST_DOWN  = 3'd3,
    GST_UP    = 3'd4,
    GST_RIGHT = 3'd5,
    GST_LEFT  = 3'd6
  } gesture_t;

  typedef struct packed {
    logic [7:0]                     count;
    logic [TIME_WIDTH-1:0]          first_time;
    logic signed [SAMPLE_WIDTH-1:0] extreme;
  } trk_stat_t;

endpackage

FILE: design/mpgc_if.sv
// ----------------------------------------------------------------------------
// mpgc interfaces
// Sample, result and register-write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpgc_in_if import mpgc_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic signed [SAMPLE_WIDTH-1:0] vertical_accel;
  logic signed [SAMPLE_WIDTH-1:0] lateral_accel;

  modport source(output valid, kind, vertical_accel, lateral_accel, input ready);
  modport sink(input valid, kind, vertical_accel, lateral_accel, output ready);
endinterface

interface mpgc_out_if import mpgc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] gesture;
  logic [7:0] vertical_crests;
  logic [7:0] vertical_troughs;
  logic [7:0] lateral_crests;
  logic [7:0] lateral_troughs;

  modport source(output valid, gesture, vertical_crests, vertical_troughs,
                 lateral_crests, lateral_troughs, input ready);
  modport sink(input valid, gesture, vertical_crests, vertical_troughs,
               lateral_crests, lateral_troughs, output ready);
endinterface

interface mpgc_cfg_if import mpgc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: design/mpgc_smooth.sv
// ----------------------------------------------------------------------------
// mpgc_smooth
// Three-sample running mean of the lateral channel, truncated toward zero.
// ----------------------------------------------------------------------------
module mpgc_smooth import mpgc_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic                           clear,
  input  logic signed [SAMPLE_WIDTH-1:0] lat,
  output logic signed [SAMPLE_WIDTH-1:0] mean
);

  localparam int SUM_W      = SAMPLE_WIDTH + 2;
  localparam int MAG_W      = SAMPLE_WIDTH + 1;
  localparam int MEAN_SHIFT = SAMPLE_WIDTH + 2;
  // ceil(2^MEAN_SHIFT / 3); exact for magnitudes below 2^(MEAN_SHIFT-1)
  localparam logic [MAG_W-1:0] MEAN_MUL =
    MAG_W'(((64'd1 << MEAN_SHIFT) + 64'd2) / 64'd3);

  logic signed [SAMPLE_WIDTH-1:0] older;
  logic signed [SAMPLE_WIDTH-1:0] newer;
  logic signed [SUM_W-1:0]        sum;
  logic signed [SUM_W-1:0]        sum_abs;
  logic                           neg;
  logic [MAG_W-1:0]               mag;
  logic [2*MAG_W-1:0]             prod;
  logic [SAMPLE_WIDTH-1:0]        quot;

  assign sum     = SUM_W'(lat) + SUM_W'(newer) + SUM_W'(older);
  assign neg     = sum[SUM_W-1];
  assign sum_abs = neg ? -sum : sum;
  assign mag     = sum_abs[MAG_W-1:0];
  assign prod    = {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, MEAN_MUL};
  assign quot    = prod[MEAN_SHIFT +: SAMPLE_WIDTH];
  assign mean    = neg ? -$signed(quot) : $signed(quot);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      older <= '0;
      newer <= '0;
    end else if (load) begin
      older <= newer;
      newer <= lat;
    end
  end

endmodule

FILE: design/mpgc_tracker.sv
// ----------------------------------------------------------------------------
// mpgc_tracker
// Crest or trough tracker: confirms an extreme after a run of samples
// falling back from it, counts it if beyond threshold, keeps stats.
// ----------------------------------------------------------------------------
`include "motion_peak_gesture_classifier_macros.svh"

module mpgc_tracker import mpgc_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           crest,
  input  logic                           step,
  input  logic                           clear,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic signed [CMP_W-1:0]        threshold,
  input  logic [7:0]                     stable_count,
  input  logic [TIME_WIDTH-1:0]          sample_time,
  output trk_stat_t                      stat
);

  logic signed [SAMPLE_WIDTH-1:0] value, value_next;
  logic                           armed, armed_next;
  logic [7:0]                     hold, hold_next, hold_inc;
  logic [7:0]                     count, count_next, count_inc;
  logic [TIME_WIDTH-1:0]          first_time, first_time_next;
  logic signed [SAMPLE_WIDTH-1:0] extreme, extreme_next;
  logic                           over_th;

  function automatic logic beyond(input logic c,
                                  input logic signed [SAMPLE_WIDTH-1:0] a,
                                  input logic signed [SAMPLE_WIDTH-1:0] b);
    return c ? (a > b) : (a < b);
  endfunction

  assign hold_inc  = (hold == 8'hFF) ? hold : hold + 8'd1;
  assign count_inc = (count == 8'hFF) ? count : count + 8'd1;
  assign over_th   = crest ? (CMP_W'(value) > threshold) : (CMP_W'(value) < threshold);

  always_comb begin
    value_next      = value;
    armed_next      = armed;
    hold_next       = hold;
    count_next      = count;
    first_time_next = first_time;
    extreme_next    = extreme;
    if (beyond(crest, x, value)) begin
      value_next = x;
      armed_next = 1'b1;
      hold_next  = '0;
    end else if (beyond(crest, value, x) && armed) begin
      hold_next = hold_inc;
      if (hold_inc > stable_count) begin
        if (over_th) begin
          count_next = count_inc;
          if (beyond(crest, value, extreme)) begin
            extreme_next = value;
          end
          if (count_inc == 8'd1) begin
            first_time_next = sample_time;
          end
        end
        value_next = '0;
        armed_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      value      <= '0;
      armed      <= 1'b1;
      hold       <= '0;
      count      <= '0;
      first_time <= '0;
      extreme    <= '0;
    end else if (step) begin
      value      <= value_next;
      armed      <= armed_next;
      hold       <= hold_next;
      count      <= count_next;
      first_time <= first_time_next;
      extreme    <= extreme_next;
    end
  end

  assign stat.count      = count;
  assign stat.first_time = first_time;
  assign stat.extreme    = extreme;

  // a disarmed tracker always restarts from zero
  `MPGC_ASSERT_IMP(a_disarmed_zero, clk, rst, !armed, value == '0)
  // counts only move up between clears
  `MPGC_ASSERT_NXT(a_count_mono, clk, rst, !clear, count >= $past(count))

endmodule

FILE: design/mpgc_classify.sv
// ----------------------------------------------------------------------------
// mpgc_classify
// Gesture decision from the four tracker statistics.
// ----------------------------------------------------------------------------
module mpgc_classify import mpgc_pkg::*; (
  input  trk_stat_t  stat [TRK_N],
  output gesture_t   gesture
);

  logic signed [SAMPLE_WIDTH:0] span_v, span_l;
  logic [SAMPLE_WIDTH:0]        abs_v, abs_l;

  assign span_v = (SAMPLE_WIDTH+1)'(stat[TRK_VC].extreme)
                - (SAMPLE_WIDTH+1)'(stat[TRK_VT].extreme);
  assign span_l = (SAMPLE_WIDTH+1)'(stat[TRK_LC].extreme)
                - (SAMPLE_WIDTH+1)'(stat[TRK_LT].extreme);
  assign abs_v  = span_v[SAMPLE_WIDTH] ? -span_v : span_v;
  assign abs_l  = span_l[SAMPLE_WIDTH] ? -span_l : span_l;

  always_comb begin
    if (stat[TRK_VC].count == 8'd0 && stat[TRK_LC].count == 8'd0) begin
      gesture = GST_NONE;
    end else if (stat[TRK_VC].count > 8'd1 || stat[TRK_LC].count > 8'd1) begin
      gesture = (stat[TRK_LC].first_time > stat[TRK_LT].first_time) ? GST_CW : GST_CCW;
    end else if (abs_v > abs_l) begin
      gesture = (stat[TRK_VC].first_time > stat[TRK_VT].first_time) ? GST_DOWN : GST_UP;
    end else begin
      gesture = (stat[TRK_LC].first_time > stat[TRK_LT].first_time) ? GST_RIGHT : GST_LEFT;
    end
  end

endmodule

FILE: design/motion_peak_gesture_classifier.sv
// A sample is registered with its smoothed lateral value on accept and updates the
// trackers in the next cycle; an end word's result is registered in the output
// register once the word leaves the input stage. Throughput: one word per cycle,
// set by the single tracker stage, unless an end word stalls. The input stage holds
// only while a result waits in the full output register. Reset (synchronous, active
// high) restores the registers to their defaults and clears all tracking state.
// ----------------------------------------------------------------------------
// motion_peak_gesture_classifier
// Crest/trough tracking of vertical and smoothed lateral acceleration with a
// gesture decision on each end word.
// ----------------------------------------------------------------------------
`include "motion_peak_gesture_classifier_macros.svh"

module motion_peak_gesture_classifier import mpgc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  mpgc_in_if.sink        samples,
  mpgc_out_if.source     results,
  mpgc_cfg_if.sink       cfg
);

  logic [14:0]                    threshold_high;
  logic signed [15:0]             threshold_low;
  logic [7:0]                     stable_count;

  logic                           in_fire;
  logic signed [SAMPLE_WIDTH-1:0] mean;

  logic                           s_valid;
  logic                           s_kind;
  logic signed [SAMPLE_WIDTH-1:0] s_vert;
  logic signed [SAMPLE_WIDTH-1:0] s_mean;
  logic                           s_go;
  logic                           step;
  logic                           fire_end;

  logic [TIME_WIDTH-1:0]          sample_time;
  logic signed [CMP_W-1:0]        th_hi, th_lo;
  trk_stat_t                      stat [TRK_N];
  gesture_t                       gesture;

  logic                           out_valid;
  logic [2:0]                     out_gesture;
  logic [7:0]                     out_cnt [TRK_N];
  logic                           trk_empty;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_high <= 15'd1638;
      threshold_low  <= -16'sd1638;
      stable_count   <= 8'd20;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_THRESHOLD_HIGH: threshold_high <= cfg.data[14:0];
        CFG_THRESHOLD_LOW:  threshold_low  <= cfg.data;
        CFG_STABLE_COUNT:   stable_count   <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // stage hand-off: only an end word can stall, on a full output register
  assign s_go          = s_valid && (s_kind == KIND_SAMPLE || !out_valid || results.ready);
  assign step          = s_go && s_kind == KIND_SAMPLE;
  assign fire_end      = s_go && s_kind == KIND_END;
  assign samples.ready = !s_valid || s_go;
  assign in_fire       = samples.valid && samples.ready;

  mpgc_smooth u_smooth (
    .clk   (clk),
    .rst   (rst),
    .load  (in_fire && samples.kind == KIND_SAMPLE),
    .clear (in_fire && samples.kind == KIND_END),
    .lat   (samples.lateral_accel),
    .mean  (mean)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (samples.ready) begin
      s_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_kind <= samples.kind;
      s_vert <= samples.vertical_accel;
      s_mean <= mean;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || fire_end) begin
      sample_time <= '0;
    end else if (step) begin
      sample_time <= sample_time + 1'b1;
    end
  end

  assign th_hi = CMP_W'(signed'({1'b0, threshold_high}));
  assign th_lo = CMP_W'(threshold_low);

  mpgc_tracker u_trk_vc (
    .clk (clk), .rst (rst), .crest (1'b1), .step (step), .clear (fire_end),
    .x (s_vert), .threshold (th_hi), .stable_count (stable_count),
    .sample_time (sample_time), .stat (stat[TRK_VC])
  );

  mpgc_tracker u_trk_vt (
    .clk (clk), .rst (rst), .crest (1'b0), .step (step), .clear (fire_end),
    .x (s_vert), .threshold (th_lo), .stable_count (stable_count),
    .sample_time (sample_time), .stat (stat[TRK_VT])
  );

  mpgc_tracker u_trk_lc (
    .clk (clk), .rst (rst), .crest (1'b1), .step (step), .clear (fire_end),
    .x (s_mean), .threshold (th_hi), .stable_count (stable_count),
    .sample_time (sample_time), .stat (stat[TRK_LC])
  );

  mpgc_tracker u_trk_lt (
    .clk (clk), .rst (rst), .crest (1'b0), .step (step), .clear (fire_end),
    .x (s_mean), .threshold (th_lo), .stable_count (stable_count),
    .sample_time (sample_time), .stat (stat[TRK_LT])
  );

  mpgc_classify u_classify (
    .stat    (stat),
    .gesture (gesture)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire_end) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_end) begin
      out_gesture <= gesture;
      for (int i = 0; i < TRK_N; i++) begin
        out_cnt[i] <= stat[i].count;
      end
    end
  end

  assign results.valid            = out_valid;
  assign results.gesture          = out_gesture;
  assign results.vertical_crests  = out_cnt[TRK_VC];
  assign results.vertical_troughs = out_cnt[TRK_VT];
  assign results.lateral_crests   = out_cnt[TRK_LC];
  assign results.lateral_troughs  = out_cnt[TRK_LT];

  assign trk_empty = (sample_time == '0) &&
                     (stat[TRK_VC].count == 8'd0) && (stat[TRK_VT].count == 8'd0) &&
                     (stat[TRK_LC].count == 8'd0) && (stat[TRK_LT].count == 8'd0);

  // end word leaves a result and a cleared tracker set behind
  `MPGC_ASSERT_NXT(a_end_result, clk, rst, fire_end, out_valid)
  `MPGC_ASSERT_NXT(a_end_clears, clk, rst, fire_end, trk_empty)
  `MPGC_ASSERT_NXT(a_time_step, clk, rst, step, sample_time == TIME_WIDTH'($past(sample_time) + 1'b1))

endmodule
